// ----- rtl/fbpa_pkg.sv -----
// Package for the fixed block pool allocator.
// Holds sizes, field codes and the command/status structs shared by the modules.
// No dependencies.
`timescale 1ns / 1ps

package fbpa_pkg;

	// pool and field sizes
	localparam int POOL_SLOTS = 1024;
	localparam int SLOT_W     = 10;
	localparam int ADDR_W     = $clog2(POOL_SLOTS);
	localparam int CNT_W      = $clog2(POOL_SLOTS + 1);
	localparam int CMP_W      = 18;
	localparam int LINK_W     = SLOT_W + 1;
	localparam int OBJ_W      = 13;
	localparam int OFF_W      = 22;
	localparam int PROD_W     = SLOT_W + OBJ_W;

	// object size limits and reset value
	localparam logic [OBJ_W-1:0] OBJ_MIN   = OBJ_W'(8);
	localparam logic [OBJ_W-1:0] OBJ_MAX   = OBJ_W'(4096);
	localparam logic [OBJ_W-1:0] OBJ_RESET = OBJ_W'(8);

	// action codes
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// status codes
	localparam logic ST_OK        = 1'b0;
	localparam logic ST_EXHAUSTED = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic capture;  // latch the accepted input beat
		logic exec;     // perform the latched request and load the result
		logic pop;      // load the free-list head from the link memory
	} fbpa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_pop;   // latched request pops the free list
		logic out_room; // result register can take a new result
	} fbpa_stat_t;

endpackage

// ----- rtl/fbpa_ram.sv -----
// Generic single-port RAM with registered read.
// Used for the per-slot link store; no dependencies.
`timescale 1ns / 1ps

module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write or read one entry per cycle
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/fbpa_ctrl.sv -----
// Controller for the fixed block pool allocator.
// Sequences capture, execute and free-list pop; uses fbpa_pkg.
`timescale 1ns / 1ps

module fbpa_ctrl
	import fbpa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  fbpa_stat_t stat,
	output fbpa_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_POP
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   accept;

	assign in_stall = !ready_q;
	assign accept   = in_valid && ready_q;

	// drive commands from the current state
	always_comb begin
		cmd.capture = accept;
		cmd.exec    = (state_q == S_EXEC) && stat.out_room;
		cmd.pop     = (state_q == S_POP);
	end

	// advance state and registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
						ready_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (stat.out_room) begin
						state_q <= stat.is_pop ? S_POP : S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_POP: begin
					// next beat may enter while the head reloads
					if (accept) begin
						state_q <= S_EXEC;
						ready_q <= 1'b0;
					end else begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

// ----- rtl/fbpa_dp.sv -----
// Datapath for the fixed block pool allocator: input latch, free-list head,
// bump counter, link memory, offset multiply and result register.
// Uses fbpa_pkg and fbpa_ram.
`timescale 1ns / 1ps

module fbpa_dp
	import fbpa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  fbpa_cmd_t         cmd,
	output fbpa_stat_t        stat,
	input  logic              action,
	input  logic [SLOT_W-1:0] slot,
	input  logic              cfg_wr_en,
	input  logic [OBJ_W-1:0]  cfg_wr_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              status,
	output logic [SLOT_W-1:0] granted_slot,
	output logic [OFF_W-1:0]  byte_offset
);

	logic              action_q;
	logic [SLOT_W-1:0] slot_q;
	logic              head_valid_q;
	logic [SLOT_W-1:0] head_idx_q;
	logic [CNT_W-1:0]  bump_q;
	logic [OBJ_W-1:0]  obj_q;

	logic              out_valid_q;
	logic              status_q;
	logic [SLOT_W-1:0] granted_q;
	logic [OFF_W-1:0]  offset_q;

	logic              ram_en;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [LINK_W-1:0] ram_wdata;
	logic [LINK_W-1:0] ram_rdata;

	logic              free_ok;
	logic              head_ok;
	logic              bump_ok;
	logic              grant_ok;
	logic [SLOT_W-1:0] grant;
	logic [OBJ_W-1:0]  size_c;
	logic [PROD_W-1:0] prod;

	// classify the latched request
	assign free_ok  = (action_q == ACT_FREE) && (CMP_W'(slot_q) < CMP_W'(POOL_SLOTS));
	assign head_ok  = head_valid_q && (CMP_W'(head_idx_q) < CMP_W'(POOL_SLOTS));
	assign bump_ok  = CMP_W'(bump_q) < CMP_W'(POOL_SLOTS);
	assign grant_ok = (action_q == ACT_ALLOC) && (head_ok || bump_ok);
	assign grant    = head_ok ? head_idx_q : SLOT_W'(bump_q);

	assign stat.is_pop   = (action_q == ACT_ALLOC) && head_ok;
	assign stat.out_room = !out_valid_q || !out_stall;

	// clamp object size and form the byte offset
	always_comb begin
		if (obj_q < OBJ_MIN) begin
			size_c = OBJ_MIN;
		end else if (obj_q > OBJ_MAX) begin
			size_c = OBJ_MAX;
		end else begin
			size_c = obj_q;
		end
		prod = PROD_W'(grant) * PROD_W'(size_c);
	end

	// link memory: push writes the old head, pop reads the head's link
	always_comb begin
		ram_en    = cmd.exec && (free_ok || stat.is_pop);
		ram_we    = (action_q == ACT_FREE);
		ram_addr  = (action_q == ACT_FREE) ? ADDR_W'(slot_q) : ADDR_W'(head_idx_q);
		ram_wdata = {head_valid_q, head_idx_q};
	end

	fbpa_ram #(
		.WIDTH(LINK_W),
		.DEPTH(POOL_SLOTS)
	) u_link_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// latch the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action;
			slot_q   <= slot;
		end
	end

	// hold the object size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_q <= OBJ_RESET;
		end else if (cfg_wr_en) begin
			obj_q <= cfg_wr_data;
		end
	end

	// update free-list head and bump counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			head_idx_q   <= '0;
			bump_q       <= '0;
		end else if (cmd.pop) begin
			head_valid_q <= ram_rdata[LINK_W-1];
			head_idx_q   <= ram_rdata[SLOT_W-1:0];
		end else if (cmd.exec) begin
			if (free_ok) begin
				head_valid_q <= 1'b1;
				head_idx_q   <= slot_q;
			end else if ((action_q == ACT_ALLOC) && !head_ok && bump_ok) begin
				bump_q <= bump_q + CNT_W'(1);
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (grant_ok) begin
				status_q  <= ST_OK;
				granted_q <= grant;
				offset_q  <= OFF_W'(prod);
			end else begin
				status_q  <= (action_q == ACT_ALLOC) ? ST_EXHAUSTED : ST_OK;
				granted_q <= '0;
				offset_q  <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign granted_slot = granted_q;
	assign byte_offset  = offset_q;

`ifndef ASSERT_OFF
	a_bump_range: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(bump_q) <= CMP_W'(POOL_SLOTS))
		else $error("bump counter past pool size");

	a_pop_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> $past(ram_en && !ram_we))
		else $error("head reload without link read");

	a_exhausted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_EXHAUSTED)) |-> (granted_q == '0 && offset_q == '0))
		else $error("exhausted result carries a grant");

	a_exec_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (!out_valid_q || !out_stall))
		else $error("result overwritten while stalled");
`endif

endmodule

// ----- rtl/fixed_block_pool_allocator.sv -----
// Fixed block pool allocator: a LIFO free list over a pool of equal slots,
// backed by a bump counter. Each request is latched on acceptance and then
// executed in S_EXEC, which waits for room in the result register; a pop's
// registered link-memory read overlaps the next request's capture. The result
// register lets a new beat enter while a finished result still waits
// downstream. No clearing pass after reset: the link memory is only read
// after a free wrote it. Top level; uses fbpa_pkg, fbpa_ctrl and fbpa_dp.
`timescale 1ns / 1ps

module fixed_block_pool_allocator
	import fbpa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	input  logic [SLOT_W-1:0] slot,
	input  logic              cfg_wr_en,
	input  logic [OBJ_W-1:0]  cfg_wr_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              status,
	output logic [SLOT_W-1:0] granted_slot,
	output logic [OFF_W-1:0]  byte_offset
);

	fbpa_cmd_t  cmd;
	fbpa_stat_t stat;

	// sequence requests
	fbpa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	// free list, counter, offset and result
	fbpa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.action      (action),
		.slot        (slot),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.granted_slot(granted_slot),
		.byte_offset (byte_offset)
	);

endmodule

// ----- tb/fixed_block_pool_allocator_tb.sv -----
// Testbench for fixed_block_pool_allocator: plans allocate/free beats, predicts each
// grant with a cycle-free model of the free list and bump counter, and checks every beat.
// Depends on fbpa_pkg and the fixed_block_pool_allocator RTL.
`timescale 1ns / 1ps

module fixed_block_pool_allocator_tb;
	import fbpa_pkg::*;

	typedef struct packed {
		logic              act;
		logic [SLOT_W-1:0] slot;
	} pool_req_t;

	typedef struct packed {
		logic              status;
		logic [SLOT_W-1:0] granted;
		logic [OFF_W-1:0]  offset;
	} pool_grant_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              action = ACT_ALLOC;
	logic [SLOT_W-1:0] slot = '0;
	logic              cfg_wr_en = 1'b0;
	logic [OBJ_W-1:0]  cfg_wr_data = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              status;
	logic [SLOT_W-1:0] granted_slot;
	logic [OFF_W-1:0]  byte_offset;

	fixed_block_pool_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.slot         (slot),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.granted_slot (granted_slot),
		.byte_offset  (byte_offset)
	);

	always #5 clk = ~clk;

	// predicted allocator state
	logic [LINK_W-1:0] model_link [POOL_SLOTS];
	logic [LINK_W-1:0] model_head = '0;
	logic [CNT_W-1:0]  model_bump = '0;
	logic [OBJ_W-1:0]  model_obj_bytes = OBJ_RESET;

	pool_req_t   pending_requests [$];
	pool_grant_t expected_grants [$];
	int          mismatch_count = 0;
	bit          idle_on = 1'b1;

	// stimulus planner shadow: LIFO of freed slots, slots held by the requester
	int plan_free_stack [$];
	int plan_held [$];
	bit plan_held_flag [POOL_SLOTS];
	int plan_bump = 0;
	int plan_exhausted = 0;

	// compute the grant for one accepted beat and advance the model
	function automatic pool_grant_t predict_grant(input pool_req_t rq);
		pool_grant_t       res;
		logic [OBJ_W-1:0]  size_eff;
		logic [PROD_W-1:0] prod;
		res = '0;
		res.status = ST_OK;
		if (rq.act == ACT_FREE) begin
			if (int'(rq.slot) < POOL_SLOTS) begin
				model_link[rq.slot] = model_head;
				model_head = {1'b1, rq.slot};
			end
			return res;
		end
		if (model_head[SLOT_W] && int'(model_head[SLOT_W-1:0]) < POOL_SLOTS) begin
			res.granted = model_head[SLOT_W-1:0];
			model_head = model_link[res.granted];
		end else if (int'(model_bump) < POOL_SLOTS) begin
			res.granted = model_bump[SLOT_W-1:0];
			model_bump = model_bump + 1'b1;
		end else begin
			res.status = ST_EXHAUSTED;
			return res;
		end
		if (model_obj_bytes < OBJ_MIN)
			size_eff = OBJ_MIN;
		else if (model_obj_bytes > OBJ_MAX)
			size_eff = OBJ_MAX;
		else
			size_eff = model_obj_bytes;
		prod = PROD_W'(res.granted) * PROD_W'(size_eff);
		res.offset = prod[OFF_W-1:0];
		return res;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// queue an allocate beat; the slot field carries junk the block ignores
	task automatic plan_alloc(input int junk);
		int g;
		pending_requests.push_back('{act: ACT_ALLOC, slot: SLOT_W'(junk)});
		if (plan_free_stack.size() != 0)
			g = plan_free_stack.pop_back();
		else if (plan_bump < POOL_SLOTS) begin
			g = plan_bump;
			plan_bump++;
		end else begin
			plan_exhausted++;
			return;
		end
		if (!plan_held_flag[g]) begin
			plan_held_flag[g] = 1'b1;
			plan_held.push_back(g);
		end
	endtask

	// queue a free of an arbitrary slot, held or not
	task automatic plan_free_slot(input int s);
		pending_requests.push_back('{act: ACT_FREE, slot: SLOT_W'(s)});
		plan_free_stack.push_back(s);
	endtask

	// queue a well-formed free of the held slot at position idx
	task automatic plan_free_at(input int idx);
		int s;
		s = plan_held[idx];
		plan_held.delete(idx);
		plan_held_flag[s] = 1'b0;
		plan_free_slot(s);
	endtask

	task automatic plan_mixed(input int n, input int alloc_pct);
		for (int i = 0; i < n; i++) begin
			if (plan_held.size() == 0 || $urandom_range(0, 99) < alloc_pct)
				plan_alloc($urandom_range(0, POOL_SLOTS - 1));
			else
				plan_free_at($urandom_range(0, plan_held.size() - 1));
		end
	endtask

	// hold until every planned beat went in and every grant came back
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_grants.size() != 0);
	endtask

	task automatic set_object_bytes(input int v);
		wait_idle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= OBJ_W'(v);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// request driver: hold a stalled beat, otherwise idle in bursts or send the next one
	int unsigned gap_left = 0;
	logic        in_beat_taken = 1'b0;
	pool_req_t   next_req;

	always @(negedge clk) begin
		if (!in_valid || in_beat_taken) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 11) == 0) begin
				gap_left <= $urandom_range(0, 18);
				in_valid <= 1'b0;
			end else if (pending_requests.size() != 0) begin
				next_req = pending_requests.pop_front();
				action <= next_req.act;
				slot <= next_req.slot;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result stall: random bursts while idling is on
	int unsigned stall_left = 0;

	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 18);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor: predict on each request beat, compare each grant beat
	pool_grant_t want;

	always @(posedge clk) begin
		in_beat_taken <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (cfg_wr_en)
				model_obj_bytes = cfg_wr_data;
			if (in_valid && !in_stall)
				expected_grants.push_back(predict_grant('{act: action, slot: slot}));
			if (out_valid && !out_stall) begin
				if (expected_grants.size() == 0) begin
					$display("%0t: unexpected grant beat, expected none, actual status %0d slot %0d offset %0d",
						$time, status, granted_slot, byte_offset);
					mismatch_count++;
				end else begin
					want = expected_grants.pop_front();
					check_field("status", want.status, status);
					check_field("granted_slot", want.granted, granted_slot);
					check_field("byte_offset", want.offset, byte_offset);
				end
			end
		end
	end

	initial begin
		int fill_count;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: bump grants, LIFO reuse, free of a never-granted slot
		plan_alloc(0);
		plan_alloc(POOL_SLOTS - 1);
		plan_alloc(0);
		plan_free_at(2);
		plan_free_at(0);
		plan_alloc(0);
		plan_alloc(0);
		plan_alloc(0);
		plan_free_slot(plan_bump);
		plan_alloc(0);
		plan_alloc(0);
		plan_free_at(0);
		plan_alloc(POOL_SLOTS - 1);

		// size below the minimum, then churn
		set_object_bytes(0);
		plan_mixed(200, 70);
		set_object_bytes(int'(OBJ_MAX));
		plan_mixed(200, 50);

		// size above the maximum; drain the pool until it runs dry repeatedly
		set_object_bytes((1 << OBJ_W) - 1);
		fill_count = 0;
		while (plan_exhausted < 40 && fill_count < 3000) begin
			plan_mixed(1, 92);
			fill_count++;
		end

		// just under the minimum, balanced traffic around an empty pool
		set_object_bytes(int'(OBJ_MIN) - 1);
		plan_mixed(150, 50);

		// from here on without idling: unchecked frees of any slot
		set_object_bytes($urandom_range(int'(OBJ_MIN), int'(OBJ_MAX)));
		idle_on = 1'b0;
		for (int i = 0; i < 150; i++) begin
			if ($urandom_range(0, 1) == 0)
				plan_alloc($urandom_range(0, POOL_SLOTS - 1));
			else
				plan_free_slot($urandom_range(0, POOL_SLOTS - 1));
		end

		// top slot at the largest offset, then a double free granted twice
		set_object_bytes(int'(OBJ_MAX) + 1);
		plan_free_slot(POOL_SLOTS - 1);
		plan_alloc(0);
		plan_free_slot(0);
		plan_free_slot(0);
		plan_alloc(POOL_SLOTS - 1);
		plan_alloc(0);

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ----- fixed_block_pool_allocator.f -----
rtl/fbpa_pkg.sv
rtl/fbpa_ram.sv
rtl/fbpa_ctrl.sv
rtl/fbpa_dp.sv
rtl/fixed_block_pool_allocator.sv
tb/fixed_block_pool_allocator_tb.sv
